// File: rtl/sha256_message_digest_macros.svh
// Assertion macros shared by the SHA-256 digest RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef SHA256_MESSAGE_DIGEST_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Signal is at most one-hot outside reset.
`define SHA_ONEHOT0(lbl, clk, rstn, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) $onehot0(sig)) else $error(msg);
`endif

// File: rtl/sha_pkg.sv
// Package for the SHA-256 digest block: types, round constants, round functions.
// No dependencies.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
  } sha_state_e;

  // Compression core sequencing
  typedef enum logic [2:0] {
    C_IDLE, C_LOADH, C_LOADW, C_ROUND, C_ADD
  } core_state_e;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  // Request from the buffer control to the compression core.
  typedef struct packed {
    logic start;
  } core_req_t;

  // Status from the compression core.
  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// File: rtl/sha256_message_digest.sv
// SHA-256 message digest top: byte intake, padding, block buffer, digest output.
// Depends on sha_pkg, sha_core and the assertion macros header.
// Throughput: one byte per cycle while filling; a full block stalls input while the core
//   starts, loads the hash, loads the words, runs the rounds and adds.
// Message end: pad one byte per cycle to the block end, then one or two compressions;
//   each digest word is read from the hash memory only after the previous word is taken.
`include "sha256_message_digest_macros.svh"
module sha256_message_digest import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero pad
  output logic        m_axis_tlast    // last_word
);

  sha_state_e  state_q, state_d;
  logic [6:0]  fill_q, fill_d;
  logic [60:0] bcnt_q, bcnt_d;
  logic        padding_q, padding_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        ovalid_q;
  logic [31:0] bufmem [16];
  logic [31:0] blk_rd_q;
  logic [3:0]  blk_addr;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [63:0] bits;
  logic        accept;
  logic        out_fire;
  core_req_t   req;
  core_sts_t   sts;
  logic [31:0] hrd_data;
  logic        hrd_en;
  logic        hinit;
  logic [31:0] digest_q;
  logic        pad_done_q, pad_done_d;
  logic        pad_seen_q, pad_seen_d;
  logic        len_blk_q, len_blk_d;
  logic        len_zone;
  logic        ovalid_d_word;
  logic        hrd_wait_q;

  sha_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .sts_o      (sts),
    .blk_addr_o (blk_addr),
    .blk_data_i (blk_rd_q),
    .hrd_en_i   (hrd_en),
    .hrd_addr_i (oidx_d),
    .hrd_data_o (hrd_data),
    .hinit_i    (hinit)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign bits     = {bcnt_q, 3'b000};

  // Next state
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bcnt_d    = bcnt_q;
    padding_d = padding_q;
    oidx_d    = oidx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser) begin
            fill_d = fill_q + 7'd1;
            bcnt_d = bcnt_q + 61'd1;
          end
          if (s_axis_tlast) begin
            padding_d = 1'b1;
          end
          if (s_axis_tuser && fill_q == 7'd63) begin
            state_d = ST_LOAD;
          end else if (s_axis_tlast) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        fill_d = fill_q + 7'd1;
        if (fill_q == 7'd63) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        fill_d  = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (sts.done) begin
          if (!padding_q) begin
            state_d = ST_IDLE;
          end else if (pad_done_q) begin
            state_d = ST_EMIT;
            oidx_d  = '0;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            state_d   = ST_IDLE;
            padding_d = 1'b0;
            bcnt_d    = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Track the pad marker, the block that holds the length, and the final block
  assign len_zone = pad_seen_q && len_blk_q && (fill_q[5:0] >= LenOffset);

  always_comb begin
    pad_seen_d = pad_seen_q;
    pad_done_d = pad_done_q;
    len_blk_d  = len_blk_q;
    if (state_q == ST_PAD && !pad_seen_q) begin
      pad_seen_d = 1'b1;
      // marker ahead of the length field: length fits in this block
      if (fill_q[5:0] < LenOffset) begin
        len_blk_d = 1'b1;
      end
    end
    // marker ran into the length field: length goes in the next block
    if (state_q == ST_LOAD && pad_seen_q) begin
      len_blk_d = 1'b1;
    end
    if (state_q == ST_PAD && len_zone && fill_q == 7'd63) begin
      pad_done_d = 1'b1;
    end
    if (state_q == ST_EMIT && out_fire && oidx_q == 3'd7) begin
      pad_seen_d = 1'b0;
      pad_done_d = 1'b0;
      len_blk_d  = 1'b0;
    end
  end

  // Byte to write into the block buffer
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = s_axis_tdata;
    case (state_q)
      ST_IDLE: wr_en = accept && s_axis_tuser;
      ST_PAD: begin
        wr_en = 1'b1;
        if (!pad_seen_q) begin
          wr_byte = PadByte;
        end else if (len_zone) begin
          wr_byte = bits[{~fill_q[2:0], 3'b111} -: 8];
        end else begin
          wr_byte = 8'h00;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Block buffer: byte writes into word entries, registered word read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (fill_q[1:0])
        2'd0: bufmem[fill_q[5:2]][31:24] <= wr_byte;
        2'd1: bufmem[fill_q[5:2]][23:16] <= wr_byte;
        2'd2: bufmem[fill_q[5:2]][15:8]  <= wr_byte;
        default: bufmem[fill_q[5:2]][7:0] <= wr_byte;
      endcase
    end
    blk_rd_q <= bufmem[blk_addr];
  end

  // Hold the digest word for output
  always_ff @(posedge clk_i) begin
    if (ovalid_d_word) begin
      digest_q <= hrd_data;
    end
  end
  assign hrd_en = (state_d == ST_EMIT) && (state_q != ST_EMIT || out_fire);
  assign ovalid_d_word = hrd_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      bcnt_q     <= '0;
      padding_q  <= 1'b0;
      oidx_q     <= '0;
      ovalid_q   <= 1'b0;
      hrd_wait_q <= 1'b0;
      pad_seen_q <= 1'b0;
      pad_done_q <= 1'b0;
      len_blk_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      bcnt_q     <= bcnt_d;
      padding_q  <= padding_d;
      oidx_q     <= oidx_d;
      pad_seen_q <= pad_seen_d;
      pad_done_q <= pad_done_d;
      len_blk_q  <= len_blk_d;
      hrd_wait_q <= hrd_en;
      if (hrd_wait_q) begin
        ovalid_q <= 1'b1;
      end else if (out_fire) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign req.start     = (state_q == ST_LOAD);
  assign hinit         = (state_q == ST_EMIT) && out_fire && (oidx_q == 3'd7);
  assign s_axis_tready = (state_q == ST_IDLE) && !sts.busy;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'b0, oidx_q, digest_q};
  assign m_axis_tlast  = (oidx_q == 3'd7);

  `SHA_ASSERT(a_out_emit, clk_i, rst_ni, m_axis_tvalid |-> state_q == ST_EMIT,
              "output valid outside emit")
  `SHA_ASSERT(a_fill_range, clk_i, rst_ni, state_q == ST_IDLE |-> fill_q < 7'd64,
              "fill count out of range")
  `SHA_ASSERT(a_no_in_busy, clk_i, rst_ni, accept |-> !sts.busy,
              "input taken during compression")

endmodule

// File: rtl/sha_core.sv
// SHA-256 compression core: one round per cycle, schedule in a 16-entry window,
// chaining hash in a one-read-port synchronous memory. Uses sha_pkg.
`include "sha256_message_digest_macros.svh"
module sha_core import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  core_req_t   req_i,
  output core_sts_t   sts_o,
  // block buffer read port (word address, registered data)
  output logic [3:0]  blk_addr_o,
  input  logic [31:0] blk_data_i,
  // chaining hash read for digest output
  input  logic        hrd_en_i,
  input  logic [2:0]  hrd_addr_i,
  output logic [31:0] hrd_data_o,
  input  logic        hinit_i
);

  core_state_e state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] hmem [8];
  logic [7:0]  hvalid_q;
  logic [31:0] hrd_q;
  logic [2:0]  hrd_idx_q;
  logic        h_rd_en;
  logic [2:0]  h_rd_addr;
  logic        h_wr_en;
  logic [2:0]  h_wr_addr;
  logic [31:0] h_wr_data;
  logic [31:0] h_rd_val;
  logic [31:0] w_new, t1, t2, w_cur;

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          state_d = C_LOADH;
          cnt_d   = '0;
        end
      end
      C_LOADH: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          state_d = C_LOADW;
          cnt_d   = '0;
        end
      end
      C_LOADW: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd16) begin
          state_d = C_ROUND;
          cnt_d   = '0;
        end
      end
      C_ROUND: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          state_d = C_ADD;
          cnt_d   = '0;
        end
      end
      C_ADD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          state_d = C_IDLE;
          cnt_d   = '0;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  // Memory port control: each read is issued in the cycle before its data is used
  always_comb begin
    h_rd_en   = 1'b0;
    h_rd_addr = '0;
    h_wr_en   = 1'b0;
    h_wr_addr = hrd_idx_q;
    h_wr_data = h_rd_val + v_q[hrd_idx_q];
    blk_addr_o = cnt_q[3:0];
    case (state_q)
      C_LOADH: begin
        h_rd_en   = (cnt_q < 7'd8);
        h_rd_addr = cnt_q[2:0];
      end
      C_ADD: begin
        h_wr_en = (cnt_q != 7'd0);
        if (cnt_q < 7'd8) begin
          h_rd_en   = 1'b1;
          h_rd_addr = cnt_q[2:0];
        end else begin
          // last add writes word 7: hand the read port to the digest output
          h_rd_en   = hrd_en_i;
          h_rd_addr = hrd_addr_i;
        end
      end
      default: begin
        h_rd_en   = hrd_en_i;
        h_rd_addr = hrd_addr_i;
      end
    endcase
  end

  // Entries not yet written since init read as the initial hash
  assign h_rd_val   = hvalid_q[hrd_idx_q] ? hrd_q : HashInit[hrd_idx_q];
  assign hrd_data_o = h_rd_val;

  always_ff @(posedge clk_i) begin
    if (h_wr_en) begin
      hmem[h_wr_addr] <= h_wr_data;
    end
    if (h_rd_en) begin
      hrd_q <= hmem[h_rd_addr];
    end
  end

  // Schedule and round datapath
  assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
  assign w_cur = (cnt_q < 7'd16) ? w_q[cnt_q[3:0]] : w_new;
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[cnt_q[5:0]] + w_cur;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_IDLE;
      cnt_q     <= '0;
      hvalid_q  <= '0;
      hrd_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      hrd_idx_q <= h_rd_addr;
      if (hinit_i) begin
        hvalid_q <= '0;
      end else if (h_wr_en) begin
        hvalid_q[h_wr_addr] <= 1'b1;
      end
    end
  end

  // Load working vars, words and run rounds
  always_ff @(posedge clk_i) begin
    if (state_q == C_LOADH && cnt_q != 7'd0) begin
      v_q[hrd_idx_q] <= h_rd_val;
    end
    if (state_q == C_LOADW && cnt_q != 7'd0) begin
      w_q[cnt_q[3:0] - 4'd1] <= blk_data_i;
    end
    if (state_q == C_ROUND) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      if (cnt_q >= 7'd16) begin
        for (int i = 0; i < 15; i++) begin
          w_q[i] <= w_q[i + 1];
        end
        w_q[15] <= w_new;
      end
    end
  end

  // Writeback adds previous hash with sum, using valid override
  assign sts_o.busy = (state_q != C_IDLE);
  assign sts_o.done = (state_q == C_ADD) && (cnt_q == 7'd8);

  `SHA_ASSERT(a_start_idle, clk_i, rst_ni, req_i.start |-> state_q == C_IDLE,
              "start while core busy")
  `SHA_ASSERT(a_no_init_busy, clk_i, rst_ni, hinit_i |-> state_q == C_IDLE,
              "hash init during compression")
  `SHA_ASSERT(a_done_idle, clk_i, rst_ni, sts_o.done |=> state_q == C_IDLE,
              "core not idle after done")

endmodule

// File: sim/sha256_message_digest_tb.sv
// Testbench for sha256_message_digest: byte stream in, digest words out.
// Predicts digests with its own SHA-256 model; depends on the RTL and sha_pkg.
`timescale 1ns / 100ps
module sha256_message_digest_tb import sha_pkg::*;;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam int unsigned MaxCycles = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha256_message_digest dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [31:0]  hash_q [8];
  logic [7:0]   blk_q [64];
  int unsigned  fill_q;
  logic [60:0]  len_q;

  byte_item_t   pending_bytes [$];
  digest_item_t expected_words [$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_cnt = 0;
  bit           stim_done = 1'b0;
  bit           in_fire = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void hash_reset();
    logic [31:0] iv [8];
    iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    for (int i = 0; i < 8; i++) hash_q[i] = iv[i];
    fill_q = 0;
    len_q = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, x, y;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      x = w[i-15];
      y = w[i-2];
      w[i] = w[i-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[i-7]
           + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endfunction

  function automatic void append_byte(logic [7:0] b);
    blk_q[fill_q] = b;
    fill_q++;
    if (fill_q == 64) begin
      compress_block();
      fill_q = 0;
    end
  endfunction

  // Advance the digest model by one accepted byte item
  function automatic void predict_digest(byte_item_t it);
    logic [63:0] bits;
    if (it.byte_present) begin
      len_q = len_q + 61'd1;
      append_byte(it.data_byte);
    end
    if (!it.last_byte) return;
    bits = {len_q, 3'b000};
    append_byte(8'h80);
    while (fill_q != 56) append_byte(8'h00);
    for (int i = 0; i < 8; i++) append_byte(bits[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++)
      expected_words.push_back('{hash_q[i], 3'(i), i == 7});
    hash_reset();
  endfunction

  function automatic void queue_msg(int len, bit empty_end);
    for (int i = 0; i < len; i++)
      pending_bytes.push_back('{8'($urandom), 1'b1, !empty_end && i == len - 1});
    if (empty_end || len == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
  endfunction

  // Driver: bursts with random gaps, change inputs on falling edge
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  byte_item_t  cur;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        predict_digest(cur);
        void'(pending_bytes.pop_front());
      end
      if (s_axis_tvalid && !in_fire) begin
        // hold the current byte
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
        cur = pending_bytes[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= cur.data_byte;
        s_axis_tuser <= cur.byte_present;
        s_axis_tlast <= cur.last_byte;
      end else begin
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
      end
      // receiver stall pattern: mostly ready, long stalls in some phases
      m_axis_tready <= ((cycle_cnt / 500) % 4 == 3) ? 1'b1
                     : ($urandom_range(0, 9) > (cycle_cnt / 2000) % 8);
    end
  end

  // Monitor: sample on rising edge
  digest_item_t got, exp_w;
  always @(posedge clk_i) begin
    cycle_cnt++;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", got);
      end else begin
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                     exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                     got.digest_word, got.word_index, got.last_word);
        end
      end
    end
    if (cycle_cnt >= MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int lens [4];
    int len;
    hash_reset();
    // Directed: empty message, one byte, pad boundaries, idle items
    queue_msg(0, 1'b1);
    pending_bytes.push_back('{8'h00, 1'b1, 1'b0});
    pending_bytes.push_back('{8'hff, 1'b0, 1'b0});
    pending_bytes.push_back('{8'hff, 1'b1, 1'b1});
    queue_msg(3, 1'b1);
    queue_msg(1, 1'b0);
    queue_msg(2, 1'b0);
    lens = '{55, 56, 63, 64};
    for (int i = 0; i < 4; i++) queue_msg(lens[i], i % 2);
    // Random messages, mostly short, with noise items
    while (pending_bytes.size() < 320) begin
      if ($urandom_range(0, 4) == 0) begin
        pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 20);
        if (len > 330 - pending_bytes.size()) len = 330 - pending_bytes.size();
        queue_msg(len, $urandom_range(0, 1));
      end
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_words.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
